// ===== src/pmd_pkg.sv =====
// Shared constants and types for the dense Prim spanning tree block.
`default_nettype none
package pmd_pkg;
   localparam int MAX_NODES_DEF   = 16;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int IDX_BITS        = 6;
   localparam int TOTAL_BITS      = 22;
   localparam int CFG_BITS        = 5;
   localparam logic [CFG_BITS-1:0] NODE_COUNT_RST = 5'd16;

   typedef struct packed {
      logic init;
      logic mark;
      logic shift;
   } ctl_type;

   typedef struct packed {
      logic                valid;
      logic                found;
      logic [IDX_BITS-1:0] idx;
   } tok_type;
endpackage
`default_nettype wire

// ===== src/pmd_cell.sv =====
// One vertex cell: key, parent and visited flag, with a search token passed to the right.
`default_nettype none
module pmd_cell #(
   parameter int MAX_NODES   = pmd_pkg::MAX_NODES_DEF,
   parameter int WEIGHT_BITS = pmd_pkg::WEIGHT_BITS_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  pmd_pkg::ctl_type                     ctl,
   input  wire  [$clog2(MAX_NODES)-1:0]         mark_idx,
   input  wire  [$clog2(MAX_NODES)-1:0]         u_vertex,
   input  wire  [$clog2(MAX_NODES+1)-1:0]       n_active,
   input  wire  [WEIGHT_BITS-1:0]               rd_weight,
   input  pmd_pkg::tok_type                     tok_left,
   input  wire  [WEIGHT_BITS:0]                 best_left,
   input  wire  [WEIGHT_BITS:0]                 nbr_key,
   input  wire  [$clog2(MAX_NODES)-1:0]         nbr_parent,
   output pmd_pkg::tok_type                     tok_right,
   output logic [WEIGHT_BITS:0]                 best_right,
   output logic [WEIGHT_BITS:0]                 key_out,
   output logic [$clog2(MAX_NODES)-1:0]         parent_out
);
   localparam int IW = $clog2(MAX_NODES);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int KW = WEIGHT_BITS + 1;
   localparam logic [KW-1:0] KEY_INF = '1;
   localparam logic [KW-1:0] KEY_RST = (CELL_INDEX == 0) ? '0 : KEY_INF;

   logic [KW-1:0]    key_ff, key_in, key_new, w_ext;
   logic [IW-1:0]    parent_ff, parent_in;
   logic             intree_ff, intree_in;
   pmd_pkg::tok_type tok_ff, tok_in;
   logic [KW-1:0]    best_ff, best_in;
   logic             active, upd, cand;

   always_comb begin
      active  = NW'(CELL_INDEX) < n_active;
      w_ext   = {1'b0, rd_weight};
      upd     = tok_left.valid && active && !intree_ff && (rd_weight != '0) && (w_ext < key_ff);
      key_new = upd ? w_ext : key_ff;
      cand    = tok_left.valid && active && !intree_ff && (key_new < best_left);
      tok_in  = tok_left;
      best_in = best_left;
      if (cand) begin
         tok_in.found = 1'b1;
         tok_in.idx   = pmd_pkg::IDX_BITS'(CELL_INDEX);
         best_in      = key_new;
      end
      key_in    = key_ff;
      parent_in = parent_ff;
      intree_in = intree_ff;
      if (ctl.init) begin
         key_in    = KEY_RST;
         parent_in = '0;
         intree_in = 1'b0;
      end else if (ctl.shift) begin
         key_in    = nbr_key;
         parent_in = nbr_parent;
      end else if (upd) begin
         key_in    = key_new;
         parent_in = u_vertex;
      end
      if (ctl.mark && (mark_idx == IW'(CELL_INDEX))) begin
         intree_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= KEY_RST;
         parent_ff <= '0;
         intree_ff <= 1'b0;
         tok_ff    <= '0;
      end else begin
         key_ff    <= key_in;
         parent_ff <= parent_in;
         intree_ff <= intree_in;
         tok_ff    <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign tok_right  = tok_ff;
   assign best_right = best_ff;
   assign key_out    = key_ff;
   assign parent_out = parent_ff;
endmodule
`default_nettype wire

// ===== src/prim_mst_dense_top.sv =====
// Top level of the dense Prim minimum spanning tree block with matrix memory and cell chain.
// The block takes one matrix entry per cycle into an internal memory while idle. The entry
// with tlast starts a run: a setup state, then up to n-1 rounds (n = node_count clamped to
// 2..MAX_NODES), each a pass of the search token along the vertex cells as memory streams a
// row of weights. Results leave at one per cycle while the receiver is ready, vertex 1 first,
// and no new entry is taken until the last result has been loaded into the output register.
`default_nettype none
module prim_mst_dense_top #(
   parameter int MAX_NODES   = pmd_pkg::MAX_NODES_DEF,
   parameter int WEIGHT_BITS = pmd_pkg::WEIGHT_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wen,
   input  wire  [4:0]  csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   // row_index [3:0], col_index [7:4], edge_weight [23:8]
   input  wire  [23:0] req_tdata,
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // vertex [3:0], parent_vertex [7:4], tree_weight [23:8], total_weight [45:24]
   output logic [47:0] rsp_tdata,
   // reached [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);
   localparam int IW = $clog2(MAX_NODES);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int KW = WEIGHT_BITS + 1;
   localparam int TW = pmd_pkg::TOTAL_BITS;
   localparam int SW = ((KW > TW) ? KW : TW) + 1;
   localparam logic [KW-1:0] KEY_INF = '1;
   localparam logic [TW-1:0] TOTAL_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_INIT  = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [pmd_pkg::CFG_BITS-1:0] node_count_ff;
   logic [NW-1:0] n_ff, n_in, rounds_ff, rounds_in, e_ff, e_in, n_clamp;
   logic [IW-1:0] u_ff, u_in, v_ff, v_in, mark_idx;
   logic          issue_ff, issue_in, inj_ff;
   logic [WEIGHT_BITS-1:0] mem [0:(2**(2*IW))-1];
   logic [WEIGHT_BITS-1:0] rd_ff;
   pmd_pkg::ctl_type ctl;
   pmd_pkg::tok_type tok [0:MAX_NODES];
   logic [KW-1:0] best [0:MAX_NODES];
   logic [KW-1:0] key_q [0:MAX_NODES];
   logic [IW-1:0] par_q [0:MAX_NODES];
   logic [3:0]  row_i, col_i;
   logic [15:0] w_i;
   logic        req_acc, wr_ok, load, got, fin;
   logic [KW-1:0] tw;
   logic [SW-1:0] sum;
   logic [TW-1:0] total_ff, total_new, o_total_ff;
   logic          out_valid_ff;
   logic [3:0]    o_vertex_ff, o_parent_ff;
   logic [15:0]   o_weight_ff;
   logic          o_reached_ff, o_final_ff;

   assign row_i   = req_tdata[3:0];
   assign col_i   = req_tdata[7:4];
   assign w_i     = req_tdata[23:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign wr_ok   = req_acc && (32'(row_i) < MAX_NODES) && (32'(col_i) < MAX_NODES);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[{IW'(row_i), IW'(col_i)}] <= WEIGHT_BITS'(w_i);
      end
      rd_ff <= mem[{u_ff, v_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= pmd_pkg::NODE_COUNT_RST;
      end else if (csr_wen) begin
         node_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (node_count_ff < 5'd2) begin
         n_clamp = NW'(2);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n_clamp = NW'(MAX_NODES);
      end else begin
         n_clamp = NW'(node_count_ff);
      end
   end

   assign tok[0]   = '0 | {inj_ff, 1'b0, {pmd_pkg::IDX_BITS{1'b0}}};
   assign best[0]  = KEY_INF;
   assign key_q[MAX_NODES] = KEY_INF;
   assign par_q[MAX_NODES] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_NODES; gi++) begin : g_cell
         pmd_cell #(
            .MAX_NODES   (MAX_NODES),
            .WEIGHT_BITS (WEIGHT_BITS),
            .CELL_INDEX  (gi)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .mark_idx   (mark_idx),
            .u_vertex   (u_ff),
            .n_active   (n_ff),
            .rd_weight  (rd_ff),
            .tok_left   (tok[gi]),
            .best_left  (best[gi]),
            .nbr_key    (key_q[gi+1]),
            .nbr_parent (par_q[gi+1]),
            .tok_right  (tok[gi+1]),
            .best_right (best[gi+1]),
            .key_out    (key_q[gi]),
            .parent_out (par_q[gi])
         );
      end
   endgenerate

   assign load = !out_valid_ff || rsp_tready;
   assign got  = key_q[1] != KEY_INF;
   assign tw   = got ? key_q[1] : '0;
   assign sum  = SW'(total_ff) + SW'(tw);
   assign total_new = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : TW'(sum);
   assign fin  = (e_ff == (n_ff - NW'(1)));

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      rounds_in = rounds_ff;
      e_in      = e_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      issue_in  = issue_ff;
      ctl       = '0;
      mark_idx  = IW'(tok[MAX_NODES].idx);
      if (issue_ff) begin
         v_in = v_ff + IW'(1);
         if (32'(v_ff) == MAX_NODES - 1) begin
            issue_in = 1'b0;
         end
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tlast) begin
               n_in     = n_clamp;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            ctl.init  = 1'b1;
            ctl.mark  = 1'b1;
            mark_idx  = '0;
            u_in      = '0;
            v_in      = '0;
            issue_in  = 1'b1;
            rounds_in = '0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (tok[MAX_NODES].valid) begin
               rounds_in = rounds_ff + NW'(1);
               if (tok[MAX_NODES].found && (rounds_in < (n_ff - NW'(1)))) begin
                  ctl.mark = 1'b1;
                  u_in     = IW'(tok[MAX_NODES].idx);
                  v_in     = '0;
                  issue_in = 1'b1;
               end else begin
                  e_in     = NW'(1);
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               ctl.shift = 1'b1;
               e_in      = e_ff + NW'(1);
               if (fin) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         inj_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         n_ff         <= NW'(2);
         rounds_ff    <= '0;
         e_ff         <= '0;
         u_ff         <= '0;
         v_ff         <= '0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         inj_ff    <= issue_ff && (v_ff == '0);
         n_ff      <= n_in;
         rounds_ff <= rounds_in;
         e_ff      <= e_in;
         u_ff      <= u_in;
         v_ff      <= v_in;
         if (state_ff == ST_EMIT && load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INIT) begin
         total_ff <= '0;
      end else if (state_ff == ST_EMIT && load) begin
         total_ff     <= total_new;
         o_total_ff   <= total_new;
         o_vertex_ff  <= 4'(e_ff);
         o_parent_ff  <= got ? 4'(par_q[1]) : 4'd0;
         o_weight_ff  <= 16'(tw);
         o_reached_ff <= got;
         o_final_ff   <= fin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, o_total_ff, o_weight_ff, o_parent_ff, o_vertex_ff};
   assign rsp_tuser  = o_reached_ff;
   assign rsp_tlast  = o_final_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("Result channel still valid after the final transaction.");
   a_token_in_round: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_NODES].valid |-> (state_ff == ST_ROUND))
      else $error("Search token left the chain outside a round.");
   a_unreached_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[23:4] == '0))
      else $error("Unreached vertex carries a parent or weight.");
   a_rounds_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rounds_ff < n_ff))
      else $error("Round count exceeds the vertex count.");
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the dense Prim minimum spanning tree block.
`timescale 1ns / 100ps
`default_nettype none

class mst_scoreboard;
   logic [15:0] adj [16][16];
   logic [4:0]  node_cfg;
   logic [47:0] exp_data [$];
   logic        exp_reached [$];
   logic        exp_final [$];
   int          errors;

   function new();
      node_cfg = 5'd16;
      errors = 0;
      foreach (adj[i, j]) adj[i][j] = '0;
   endfunction

   function void note_entry(logic [3:0] row, logic [3:0] col, logic [15:0] w, logic lst);
      logic [16:0] key [16];
      logic [3:0]  par [16];
      bit          done [16];
      int          n, u, best, tot;
      logic [15:0] tw;
      logic        got;
      adj[row][col] = w;
      if (!lst) return;
      n = (node_cfg < 2) ? 2 : (node_cfg > 16) ? 16 : node_cfg;
      for (int i = 0; i < 16; i++) begin
         key[i] = '1;
         par[i] = '0;
         done[i] = 0;
      end
      key[0] = '0;
      for (int r = 0; r + 1 < n; r++) begin
         u = -1;
         best = 17'h1ffff;
         for (int i = 0; i < n; i++)
            if (!done[i] && key[i] < best) begin
               best = key[i];
               u = i;
            end
         if (u < 0) break;
         done[u] = 1;
         for (int v = 0; v < n; v++)
            if (adj[u][v] != 0 && !done[v] && adj[u][v] < key[v]) begin
               key[v] = adj[u][v];
               par[v] = 4'(u);
            end
      end
      tot = 0;
      for (int i = 1; i < n; i++) begin
         got = (key[i] != 17'h1ffff);
         tw = got ? key[i][15:0] : '0;
         tot = tot + tw;
         if (tot > 22'h3fffff) tot = 22'h3fffff;
         exp_data.push_back({2'b00, tot[21:0], tw, got ? par[i] : 4'd0, 4'(i)});
         exp_reached.push_back(got);
         exp_final.push_back(i + 1 == n);
      end
   endfunction

   function void check_result(logic [47:0] d, logic reached, logic fin);
      logic [47:0] ed;
      logic er, ef;
      if (exp_data.size() == 0) begin
         $display("%0t: unexpected result data=%h reached=%b last=%b", $time, d, reached, fin);
         errors++;
         return;
      end
      ed = exp_data.pop_front();
      er = exp_reached.pop_front();
      ef = exp_final.pop_front();
      if (d[3:0] !== ed[3:0])
         $display("%0t: vertex exp %0d got %0d", $time, ed[3:0], d[3:0]);
      if (d[7:4] !== ed[7:4])
         $display("%0t: parent exp %0d got %0d", $time, ed[7:4], d[7:4]);
      if (d[23:8] !== ed[23:8])
         $display("%0t: weight exp %0d got %0d", $time, ed[23:8], d[23:8]);
      if (d[45:24] !== ed[45:24])
         $display("%0t: total exp %0d got %0d", $time, ed[45:24], d[45:24]);
      if (reached !== er) $display("%0t: reached exp %b got %b", $time, er, reached);
      if (fin !== ef) $display("%0t: last exp %b got %b", $time, ef, fin);
      if (d[45:0] !== ed[45:0] || reached !== er || fin !== ef) errors++;
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wen = 0;
   logic [4:0]  csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int send_idle = 0;
   int recv_stall = 0;
   mst_scoreboard sb;

   prim_mst_dense_top u_top (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   function automatic logic [15:0] rand_weight(input bit big);
      if ($urandom_range(3) == 0) return 16'd0;
      return big ? 16'($urandom_range(65535, 40000)) : 16'($urandom_range(20, 1));
   endfunction

   task automatic send_entry(input logic [3:0] row, input logic [3:0] col,
                             input logic [15:0] w, input logic lst);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {w, col, row};
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_entry(row, col, w, lst);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.exp_data.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_nodes(input logic [4:0] v);
      csr_wen <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 0;
      sb.node_cfg = v;
   endtask

   task automatic load_graph(input int n, input int density, input bit big);
      logic [15:0] w;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < 16; j++) begin
            w = (j < n && $urandom_range(99) < density) ?
                (big ? 16'($urandom_range(65535, 40000)) : 16'($urandom_range(20, 1))) : 16'd0;
            send_entry(4'(i), 4'(j), w, 0);
         end
   endtask

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [4:0] sizes [6];
      sb = new();
      sizes = '{5'd2, 5'd5, 5'd3, 5'd0, 5'd31, 5'd4};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      load_graph(6, 60, 0);
      send_entry(4'd5, 4'd4, 16'hffff, 1);
      drain();
      set_nodes(5'd16);
      send_entry(0, 1, 16'd0, 0);
      send_entry(0, 2, 16'd7, 0);
      send_entry(2, 1, 16'd7, 0);
      send_entry(0, 5, 16'd1, 1);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 73 : 36) : 0;
         recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 73 : 36) : 0;
         for (int k = 0; k < 6; k++) begin
            drain();
            set_nodes(sizes[(k + ph) % 6]);
            for (int r = 0; r < 4; r++)
               send_entry(4'($urandom_range(5)), 4'($urandom_range(5)), rand_weight(k == 5), 0);
            send_entry(4'($urandom_range(5)), 4'($urandom_range(5)), rand_weight(k == 5), 1);
         end
      end
      drain();
      set_nodes(5'd16);
      send_entry(3, 4, 16'd1, 1);
      drain();
      if (sb.errors == 0 && sb.exp_data.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
